// ----- src/fds_pkg.sv -----
// Shared types and codes for the FOP-1 directive handler.
`timescale 1ns / 1ps
package fds_pkg;

	// Directive codes
	localparam logic [3:0] OP_INIT_NO_CLCW = 4'd0;
	localparam logic [3:0] OP_INIT_CLCW    = 4'd1;
	localparam logic [3:0] OP_INIT_UNLOCK  = 4'd2;
	localparam logic [3:0] OP_INIT_SET_VR  = 4'd3;
	localparam logic [3:0] OP_TERMINATE    = 4'd4;
	localparam logic [3:0] OP_RESUME       = 4'd5;
	localparam logic [3:0] OP_SET_VS       = 4'd6;
	localparam logic [3:0] OP_SET_WINDOW   = 4'd7;
	localparam logic [3:0] OP_SET_T1       = 4'd8;
	localparam logic [3:0] OP_SET_LIMIT    = 4'd9;
	localparam logic [3:0] OP_SET_TIMEOUT  = 4'd10;
	localparam logic [3:0] OP_SET_SUSPEND  = 4'd11;

	// FOP states
	localparam logic [2:0] ST_INITIAL   = 3'd0;
	localparam logic [2:0] ST_ACTIVE    = 3'd1;
	localparam logic [2:0] ST_RETX_NOW  = 3'd2;
	localparam logic [2:0] ST_RETX_WAIT = 3'd3;
	localparam logic [2:0] ST_INIT_NOBC = 3'd4;
	localparam logic [2:0] ST_INIT_BC   = 3'd5;

	// Suspend states that a resume restores
	localparam logic [2:0] SS_NONE      = 3'd0;
	localparam logic [2:0] SS_ACTIVE    = 3'd1;
	localparam logic [2:0] SS_RETX_NOW  = 3'd2;
	localparam logic [2:0] SS_RETX_WAIT = 3'd3;
	localparam logic [2:0] SS_INIT_NOBC = 3'd4;

	// BC frame kinds
	localparam logic [1:0] BC_NONE   = 2'd0;
	localparam logic [1:0] BC_UNLOCK = 2'd1;
	localparam logic [1:0] BC_SET_VR = 2'd2;

	typedef struct packed {
		logic [3:0]  operation;
		logic [7:0]  channel;
		logic [31:0] directive_value;
		logic        bc_out_ready;
	} request_t;

	typedef struct packed {
		logic       accepted;
		logic       rejected;
		logic       confirmed;
		logic       alert_terminate;
		logic       initialized;
		logic       timer_started;
		logic [1:0] bc_frame_kind;
		logic [7:0] bc_vr_value;
		logic       channel_invalid;
		logic [2:0] fop_state_out;
	} result_t;

	// One channel entry of the state memory
	typedef struct packed {
		logic [2:0]  fop_state;
		logic [2:0]  suspend_state;
		logic [7:0]  send_sequence;
		logic [7:0]  expected_ack;
		logic [7:0]  window_width;
		logic [31:0] timer_initial;
		logic [31:0] transmit_limit;
		logic [7:0]  timeout_type;
	} entry_t;

	// Outcome of one directive: result, updated entry and write strobe
	typedef struct packed {
		result_t res;
		entry_t  next;
		logic    write;
	} decision_t;

endpackage

// ----- src/fds_decide.sv -----
// Directive decision logic: checks one channel entry and builds its update.
`timescale 1ns / 1ps
module fds_decide
	import fds_pkg::*;
(
	input  request_t  request,
	input  logic      in_range,
	input  entry_t    entry,
	output decision_t decision
);

	logic [7:0] lo;
	logic       init_ok;
	logic       bc_ok;

	assign lo      = request.directive_value[7:0];
	assign init_ok = (entry.fop_state == ST_INITIAL);
	assign bc_ok   = init_ok && request.bc_out_ready;

	// Decode the directive against the stored state
	always_comb begin
		decision       = '0;
		decision.next  = entry;
		decision.write = in_range;
		unique case (request.operation)
			OP_INIT_NO_CLCW: begin
				if (init_ok) begin
					decision.res.accepted      = 1'b1;
					decision.res.initialized   = 1'b1;
					decision.res.confirmed     = 1'b1;
					decision.next.suspend_state = SS_NONE;
					decision.next.fop_state    = ST_ACTIVE;
				end else begin
					decision.res.rejected = 1'b1;
				end
			end
			OP_INIT_CLCW: begin
				if (init_ok) begin
					decision.res.accepted      = 1'b1;
					decision.res.initialized   = 1'b1;
					decision.res.timer_started = 1'b1;
					decision.next.suspend_state = SS_NONE;
					decision.next.fop_state    = ST_INIT_NOBC;
				end else begin
					decision.res.rejected = 1'b1;
				end
			end
			OP_INIT_UNLOCK: begin
				if (bc_ok) begin
					decision.res.accepted      = 1'b1;
					decision.res.initialized   = 1'b1;
					decision.res.bc_frame_kind = BC_UNLOCK;
					decision.next.suspend_state = SS_NONE;
					decision.next.fop_state    = ST_INIT_BC;
				end else begin
					decision.res.rejected = 1'b1;
				end
			end
			OP_INIT_SET_VR: begin
				if (bc_ok) begin
					decision.res.accepted      = 1'b1;
					decision.res.initialized   = 1'b1;
					decision.res.bc_frame_kind = BC_SET_VR;
					decision.res.bc_vr_value   = lo;
					decision.next.suspend_state = SS_NONE;
					decision.next.expected_ack = lo;
					decision.next.send_sequence = lo;
					decision.next.fop_state    = ST_INIT_BC;
				end else begin
					decision.res.rejected = 1'b1;
				end
			end
			OP_TERMINATE: begin
				decision.res.accepted        = 1'b1;
				decision.res.confirmed       = 1'b1;
				decision.res.alert_terminate = !init_ok;
				decision.next.fop_state      = ST_INITIAL;
			end
			OP_RESUME: begin
				// Restore the state that the suspend recorded
				decision.res.accepted      = 1'b1;
				decision.res.timer_started = 1'b1;
				decision.res.confirmed     = 1'b1;
				decision.next.suspend_state = SS_NONE;
				unique case (entry.suspend_state)
					SS_ACTIVE:    decision.next.fop_state = ST_ACTIVE;
					SS_RETX_NOW:  decision.next.fop_state = ST_RETX_NOW;
					SS_RETX_WAIT: decision.next.fop_state = ST_RETX_WAIT;
					SS_INIT_NOBC: decision.next.fop_state = ST_INIT_NOBC;
					default: begin
						// not suspended, or an undefined code: reject, keep entry
						decision.res  = '0;
						decision.res.rejected = 1'b1;
						decision.next = entry;
					end
				endcase
			end
			OP_SET_VS: begin
				if (init_ok && entry.suspend_state == SS_NONE) begin
					decision.res.accepted       = 1'b1;
					decision.res.confirmed      = 1'b1;
					decision.next.send_sequence = lo;
					decision.next.expected_ack  = lo;
				end else begin
					decision.res.rejected = 1'b1;
				end
			end
			OP_SET_WINDOW: begin
				decision.res.accepted      = 1'b1;
				decision.res.confirmed     = 1'b1;
				decision.next.window_width = lo;
			end
			OP_SET_T1: begin
				decision.res.accepted       = 1'b1;
				decision.res.confirmed      = 1'b1;
				decision.next.timer_initial = request.directive_value;
			end
			OP_SET_LIMIT: begin
				decision.res.accepted        = 1'b1;
				decision.res.confirmed       = 1'b1;
				decision.next.transmit_limit = request.directive_value;
			end
			OP_SET_TIMEOUT: begin
				decision.res.accepted      = 1'b1;
				decision.res.confirmed     = 1'b1;
				decision.next.timeout_type = lo;
			end
			OP_SET_SUSPEND: begin
				decision.next.suspend_state = request.directive_value[2:0];
			end
			default: begin
				decision.res.rejected = 1'b1;
			end
		endcase

		decision.res.fop_state_out = decision.next.fop_state;

		// Drop everything for a channel outside the table
		if (!in_range) begin
			decision.res                 = '0;
			decision.res.channel_invalid = 1'b1;
			decision.write               = 1'b0;
		end
	end

endmodule

// ----- src/fop_directive_state_machine.sv -----
// Top level of the FOP-1 management directive handler.
//
// Usage:
//   The request channel (request_valid / request_stall / request) carries one
//   directive: operation, channel, directive_value and bc_out_ready. The
//   result channel (result_valid / result_stall / result) returns exactly one
//   result per request, in order.
//   All per-channel FOP state sits in one synchronous memory, one entry per
//   channel. A request reads its entry into a register at the accept edge;
//   once the output register is free, the entry is decided, written back and
//   the result is loaded into the output register, which drives result_valid.
//   A new request is taken only after the previous entry is written back, as
//   set by the read-then-write of the channel entry; request_stall is high
//   while an entry is in flight.
//   If the receiver stalls, the result holds in the output register; one
//   more request can be read meanwhile and then waits until the register
//   frees.
//   Reset clears per-entry valid bits, so every channel reads as all zero
//   (initial state) right after reset; no clearing pass is needed.
//   Channels at or above NUM_CHANNELS return only channel_invalid.
`timescale 1ns / 1ps
module fop_directive_state_machine
	import fds_pkg::*;
#(
	parameter int NUM_CHANNELS = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     request_valid,
	output logic     request_stall,
	input  request_t request,
	output logic     result_valid,
	input  logic     result_stall,
	output result_t  result
);

	localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	entry_t                  mem_q [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] entry_valid_q;

	logic            accept;
	logic            advance;
	logic [AW-1:0]   rd_addr;
	logic            busy_s1;
	request_t        request_s1;
	logic [AW-1:0]   addr_s1;
	logic            in_range_s1;
	entry_t          rd_data_s1;
	logic            rd_valid_s1;
	entry_t          entry;
	decision_t       decision;
	logic            result_valid_q;
	result_t         result_q;

	assign accept        = request_valid && !request_stall;
	assign request_stall = busy_s1;
	assign advance       = busy_s1 && (!result_valid_q || !result_stall);
	assign rd_addr       = request.channel[AW-1:0];

	// Track the request whose entry is being read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (accept) begin
			busy_s1 <= 1'b1;
		end else if (advance) begin
			busy_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			request_s1  <= request;
			addr_s1     <= rd_addr;
			in_range_s1 <= (request.channel < 8'(NUM_CHANNELS));
			rd_valid_s1 <= entry_valid_q[rd_addr];
		end
	end

	// Read the channel entry
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
	end

	// Entry never written reads as its reset value
	assign entry = rd_valid_s1 ? rd_data_s1 : '0;

	fds_decide u_decide (
		.request  (request_s1),
		.in_range (in_range_s1),
		.entry    (entry),
		.decision (decision)
	);

	// Write back the updated entry
	always_ff @(posedge clk) begin
		if (advance && decision.write) begin
			mem_q[addr_s1] <= decision.next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
		end else if (advance && decision.write) begin
			entry_valid_q[addr_s1] <= 1'b1;
		end
	end

	// Output register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= decision.res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// One entry in flight at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> request_stall)
		else $error("request accepted while an entry was in flight");

	// A blocked entry keeps its read data until it can be written back
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 && !advance |=> busy_s1 && $stable(rd_data_s1) && $stable(addr_s1))
		else $error("blocked entry lost its read data");

	// A written entry is marked valid on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && decision.write |=> entry_valid_q[$past(addr_s1)])
		else $error("written entry not marked valid");

	// Accept and reject never appear together
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.accepted && result.rejected))
		else $error("result both accepted and rejected");

endmodule

// ----- tb/fop_directive_checker.sv -----
// Checker for the FOP-1 directive handler: predicts each result and compares it.
`timescale 1ns / 1ps
module fop_directive_checker
	import fds_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     request_valid,
	input  logic     request_stall,
	input  request_t request,
	input  logic     result_valid,
	input  logic     result_stall,
	input  result_t  result,
	output int       mismatch_count,
	output int       open_results
);

	localparam int CHANNEL_COUNT = 64;
	localparam int REPORT_LIMIT  = 10;

	// Per-channel copy of the directive state
	entry_t  channel_table [CHANNEL_COUNT];
	result_t expected_q [$];
	result_t want;
	int      results_seen;

	// Work out the result of one directive and update the channel entry
	function automatic result_t apply_directive(request_t req);
		result_t    res;
		entry_t     ent;
		logic [7:0] lo;
		res = '0;
		if (req.channel >= CHANNEL_COUNT) begin
			res.channel_invalid = 1'b1;
			return res;
		end
		ent = channel_table[req.channel[5:0]];
		lo  = req.directive_value[7:0];
		case (req.operation)
			OP_INIT_NO_CLCW: begin
				if (ent.fop_state == ST_INITIAL) begin
					res.accepted      = 1'b1;
					res.initialized   = 1'b1;
					res.confirmed     = 1'b1;
					ent.suspend_state = SS_NONE;
					ent.fop_state     = ST_ACTIVE;
				end else
					res.rejected = 1'b1;
			end
			OP_INIT_CLCW: begin
				if (ent.fop_state == ST_INITIAL) begin
					res.accepted      = 1'b1;
					res.initialized   = 1'b1;
					res.timer_started = 1'b1;
					ent.suspend_state = SS_NONE;
					ent.fop_state     = ST_INIT_NOBC;
				end else
					res.rejected = 1'b1;
			end
			OP_INIT_UNLOCK: begin
				if (req.bc_out_ready && ent.fop_state == ST_INITIAL) begin
					res.accepted      = 1'b1;
					res.initialized   = 1'b1;
					res.bc_frame_kind = BC_UNLOCK;
					ent.suspend_state = SS_NONE;
					ent.fop_state     = ST_INIT_BC;
				end else
					res.rejected = 1'b1;
			end
			OP_INIT_SET_VR: begin
				if (req.bc_out_ready && ent.fop_state == ST_INITIAL) begin
					res.accepted      = 1'b1;
					res.initialized   = 1'b1;
					res.bc_frame_kind = BC_SET_VR;
					res.bc_vr_value   = lo;
					ent.suspend_state = SS_NONE;
					ent.expected_ack  = lo;
					ent.send_sequence = lo;
					ent.fop_state     = ST_INIT_BC;
				end else
					res.rejected = 1'b1;
			end
			OP_TERMINATE: begin
				res.accepted        = 1'b1;
				res.confirmed       = 1'b1;
				res.alert_terminate = (ent.fop_state != ST_INITIAL);
				ent.fop_state       = ST_INITIAL;
			end
			OP_RESUME: begin
				// Restore the state that the suspend recorded
				case (ent.suspend_state)
					SS_ACTIVE, SS_RETX_NOW, SS_RETX_WAIT, SS_INIT_NOBC: begin
						res.accepted      = 1'b1;
						res.timer_started = 1'b1;
						res.confirmed     = 1'b1;
						case (ent.suspend_state)
							SS_ACTIVE:    ent.fop_state = ST_ACTIVE;
							SS_RETX_NOW:  ent.fop_state = ST_RETX_NOW;
							SS_RETX_WAIT: ent.fop_state = ST_RETX_WAIT;
							default:      ent.fop_state = ST_INIT_NOBC;
						endcase
						ent.suspend_state = SS_NONE;
					end
					default: res.rejected = 1'b1;
				endcase
			end
			OP_SET_VS: begin
				if (ent.fop_state == ST_INITIAL && ent.suspend_state == SS_NONE) begin
					res.accepted      = 1'b1;
					res.confirmed     = 1'b1;
					ent.send_sequence = lo;
					ent.expected_ack  = lo;
				end else
					res.rejected = 1'b1;
			end
			OP_SET_WINDOW: begin
				res.accepted     = 1'b1;
				res.confirmed    = 1'b1;
				ent.window_width = lo;
			end
			OP_SET_T1: begin
				res.accepted      = 1'b1;
				res.confirmed     = 1'b1;
				ent.timer_initial = req.directive_value;
			end
			OP_SET_LIMIT: begin
				res.accepted       = 1'b1;
				res.confirmed      = 1'b1;
				ent.transmit_limit = req.directive_value;
			end
			OP_SET_TIMEOUT: begin
				res.accepted     = 1'b1;
				res.confirmed    = 1'b1;
				ent.timeout_type = lo;
			end
			OP_SET_SUSPEND: ent.suspend_state = req.directive_value[2:0];
			default: res.rejected = 1'b1;
		endcase
		channel_table[req.channel[5:0]] = ent;
		res.fop_state_out = ent.fop_state;
		return res;
	endfunction

	// Count a field mismatch; report only the first few
	task automatic compare_field(input string field, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (want_v !== got_v) begin
			if (mismatch_count < REPORT_LIMIT)
				$display("result %0d: %s expected %0h, got %0h", results_seen, field,
					want_v, got_v);
			mismatch_count++;
		end
	endtask

	// Retire results first, then queue the prediction for a new request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNEL_COUNT; i++)
				channel_table[i] = '0;
			expected_q.delete();
			open_results   = 0;
			mismatch_count = 0;
			results_seen   = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_q.size() == 0) begin
					if (mismatch_count < REPORT_LIMIT)
						$display("result %0d arrived with no request outstanding: %h",
							results_seen, result);
					mismatch_count++;
				end else begin
					want = expected_q.pop_front();
					compare_field("accepted", 32'(want.accepted), 32'(result.accepted));
					compare_field("rejected", 32'(want.rejected), 32'(result.rejected));
					compare_field("confirmed", 32'(want.confirmed), 32'(result.confirmed));
					compare_field("alert_terminate", 32'(want.alert_terminate),
						32'(result.alert_terminate));
					compare_field("initialized", 32'(want.initialized),
						32'(result.initialized));
					compare_field("timer_started", 32'(want.timer_started),
						32'(result.timer_started));
					compare_field("bc_frame_kind", 32'(want.bc_frame_kind),
						32'(result.bc_frame_kind));
					compare_field("bc_vr_value", 32'(want.bc_vr_value),
						32'(result.bc_vr_value));
					compare_field("channel_invalid", 32'(want.channel_invalid),
						32'(result.channel_invalid));
					compare_field("fop_state_out", 32'(want.fop_state_out),
						32'(result.fop_state_out));
				end
				results_seen++;
			end
			if (request_valid && !request_stall)
				expected_q.push_back(apply_directive(request));
			open_results = expected_q.size();
		end
	end

endmodule

// ----- tb/fop_directive_state_machine_tb.sv -----
// Testbench top for the FOP-1 directive handler: stimulus, idling and verdict.
`timescale 1ns / 1ps
module fop_directive_state_machine_tb
	import fds_pkg::*;
();

	localparam int         CHANNEL_COUNT   = 64;
	localparam logic [3:0] OP_UNDEFINED_LO = 4'd12;
	localparam logic [3:0] OP_UNDEFINED_HI = 4'd15;
	localparam int         PHASE_COUNT     = 4;
	localparam int         PHASE_ITEMS     = 94;

	logic     clk;
	logic     arst_n;
	logic     request_valid;
	logic     request_stall;
	request_t request;
	logic     result_valid;
	logic     result_stall;
	result_t  result;
	int       mismatch_count;
	int       open_results;
	int       idle_pct;
	int       stall_pct;
	request_t directive_q [$];

	int idle_by_phase  [PHASE_COUNT] = '{0, 82, 0, 20};
	int stall_by_phase [PHASE_COUNT] = '{0, 0, 82, 20};

	fop_directive_state_machine dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.request_valid(request_valid),
		.request_stall(request_stall),
		.request      (request),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	fop_directive_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.request_valid (request_valid),
		.request_stall (request_stall),
		.request       (request),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result        (result),
		.mismatch_count(mismatch_count),
		.open_results  (open_results)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Give up on a hung run
	initial begin
		#2_000_000;
		$display("fop_directive_state_machine_tb failed");
		$finish;
	end

	// Stall the result side at random, changing at the falling edge
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			result_stall = ($urandom_range(99) < stall_pct);
		end
	end

	task automatic add_directive(input logic [3:0] op, input logic [7:0] ch,
			input logic [31:0] val, input logic rdy);
		request_t req;
		req.operation       = op;
		req.channel         = ch;
		req.directive_value = val;
		req.bc_out_ready    = rdy;
		directive_q.push_back(req);
	endtask

	// Favor a few channels so their state evolves; sometimes go out of range
	function automatic logic [7:0] pick_channel();
		int roll;
		roll = $urandom_range(99);
		if (roll < 70)
			return 8'($urandom_range(3));
		else if (roll < 80)
			return 8'(CHANNEL_COUNT - 1);
		else if (roll < 93)
			return 8'($urandom_range(CHANNEL_COUNT - 1));
		return 8'($urandom_range(255, CHANNEL_COUNT));
	endfunction

	// Fill the queue with short directive sequences and some noise
	task automatic build_random_batch(input int count);
		int         target;
		int         kind;
		logic [7:0] ch;
		target = directive_q.size() + count;
		while (directive_q.size() < target) begin
			kind = $urandom_range(9);
			ch   = pick_channel();
			case (kind)
				0, 1, 2: add_directive(4'($urandom_range(OP_UNDEFINED_HI)), ch, $urandom,
					1'($urandom_range(1)));
				3, 4: begin
					add_directive(OP_TERMINATE, ch, $urandom, 1'($urandom_range(1)));
					add_directive(4'($urandom_range(OP_INIT_SET_VR)), ch, $urandom,
						$urandom_range(3) != 0);
				end
				5, 6: begin
					add_directive(OP_SET_SUSPEND, ch, $urandom, 1'($urandom_range(1)));
					add_directive(OP_RESUME, ch, $urandom, 1'($urandom_range(1)));
				end
				7: begin
					add_directive(OP_TERMINATE, ch, $urandom, 1'($urandom_range(1)));
					add_directive(OP_SET_VS, ch, $urandom, 1'($urandom_range(1)));
					add_directive(OP_INIT_SET_VR, ch, $urandom, $urandom_range(3) != 0);
				end
				default: add_directive(4'($urandom_range(OP_SET_TIMEOUT, OP_SET_WINDOW)), ch,
					$urandom, 1'($urandom_range(1)));
			endcase
		end
	endtask

	// Send queued requests, idling between them as the phase asks
	task automatic issue_directives();
		request_t req;
		while (directive_q.size() > 0) begin
			req = directive_q.pop_front();
			while ($urandom_range(99) < idle_pct) begin
				request_valid = 1'b0;
				@(negedge clk);
			end
			request_valid = 1'b1;
			request       = req;
			do
				@(posedge clk);
			while (request_stall);
			@(negedge clk);
		end
		request_valid = 1'b0;
	endtask

	// Hold off until every request has its result
	task automatic drain_results();
		wait (open_results == 0);
		@(negedge clk);
	endtask

	initial begin
		arst_n        = 1'b0;
		request_valid = 1'b0;
		request       = '0;
		idle_pct      = 0;
		stall_pct     = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: reject paths, every initiate, terminate alert, resume cases
		add_directive(OP_RESUME, 8'd0, 32'h0, 1'b1);
		add_directive(OP_SET_VS, 8'd0, 32'hffff_ffff, 1'b1);
		add_directive(OP_INIT_NO_CLCW, 8'd0, 32'h0, 1'b0);
		add_directive(OP_INIT_NO_CLCW, 8'd0, 32'h0, 1'b1);
		add_directive(OP_SET_VS, 8'd0, 32'h0000_0012, 1'b1);
		add_directive(OP_TERMINATE, 8'd0, 32'h0, 1'b1);
		add_directive(OP_TERMINATE, 8'd0, 32'hffff_ffff, 1'b0);
		add_directive(OP_INIT_CLCW, 8'd1, 32'h0, 1'b0);
		add_directive(OP_INIT_UNLOCK, 8'd2, 32'h0, 1'b0);
		add_directive(OP_INIT_UNLOCK, 8'd2, 32'h0, 1'b1);
		add_directive(OP_INIT_SET_VR, 8'd3, 32'h0000_0082, 1'b0);
		add_directive(OP_INIT_SET_VR, 8'd3, 32'h5a5a_a582, 1'b1);
		add_directive(OP_SET_WINDOW, 8'd63, 32'hffff_ffff, 1'b1);
		add_directive(OP_SET_T1, 8'd63, 32'hffff_ffff, 1'b1);
		add_directive(OP_SET_LIMIT, 8'd63, 32'h0, 1'b1);
		add_directive(OP_SET_TIMEOUT, 8'd63, 32'h0000_00ff, 1'b1);
		add_directive(OP_SET_SUSPEND, 8'd63, 32'hffff_fffd, 1'b1);
		add_directive(OP_RESUME, 8'd63, 32'h0, 1'b1);
		add_directive(OP_SET_SUSPEND, 8'd63, 32'h0000_0004, 1'b1);
		add_directive(OP_RESUME, 8'd63, 32'h0, 1'b1);
		add_directive(OP_SET_SUSPEND, 8'd4, 32'h0000_0003, 1'b1);
		add_directive(OP_SET_VS, 8'd4, 32'h0000_0001, 1'b1);
		add_directive(OP_INIT_NO_CLCW, 8'd4, 32'h0, 1'b1);
		add_directive(OP_RESUME, 8'd4, 32'h0, 1'b1);
		add_directive(OP_UNDEFINED_LO, 8'd5, 32'h0, 1'b1);
		add_directive(OP_UNDEFINED_HI, 8'd5, 32'hffff_ffff, 1'b1);
		add_directive(OP_SET_WINDOW, 8'(CHANNEL_COUNT), 32'h0, 1'b1);
		add_directive(OP_TERMINATE, 8'hff, 32'hffff_ffff, 1'b1);
		issue_directives();

		// Random phases under different idle and stall pressure
		for (int p = 0; p < PHASE_COUNT; p++) begin
			idle_pct  = idle_by_phase[p];
			stall_pct = stall_by_phase[p];
			build_random_batch(PHASE_ITEMS);
			issue_directives();
			if (p == 1)
				drain_results();
		end

		drain_results();
		repeat (8) @(negedge clk);
		if (mismatch_count == 0 && open_results == 0)
			$display("fop_directive_state_machine_tb passed");
		else
			$display("fop_directive_state_machine_tb failed");
		$finish;
	end

endmodule
